FILE: rtl/swipe_velocity_window_defines.svh
// assertion macros shared by the swipe velocity window rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef SWIPE_VELOCITY_WINDOW_DEFINES_SVH
`define SWIPE_VELOCITY_WINDOW_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define SVW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svw: same-cycle check failed");

// antecedent holds, consequent holds in the next cycle
`define SVW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svw: next-cycle check failed");

// condition never seen
`define SVW_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("svw: forbidden condition seen");

`endif

FILE: rtl/svw_pkg.sv
// package for the swipe velocity window block
// constants, codes and the sequencer state type; no dependencies
package svw_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int TIME_BITS      = 32;
  localparam int WIN_BITS       = 10;
  localparam int VEL_BITS       = 27;
  localparam int MS_PER_SEC     = 1000;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(150);

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_BITS-3:0] REG_WINDOW_MS = '0;

  // input opcodes
  localparam logic OP_MOVE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIM,
    ST_WRITE,
    ST_RD_OLD,
    ST_DIFF,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } back_state_t;

endpackage

FILE: rtl/svw_if.sv
// channel interfaces for the swipe velocity window block
// depends on svw_pkg for default widths
interface svw_in_if #(
  parameter int COORD_BITS = svw_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [svw_pkg::TIME_BITS-1:0] event_time;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, opcode, event_time, pos_x, pos_y, input ready);
  modport sink (input valid, opcode, event_time, pos_x, pos_y, output ready);
endinterface

interface svw_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [svw_pkg::VEL_BITS-1:0] vel_x;
  logic signed [svw_pkg::VEL_BITS-1:0] vel_y;
  logic                               is_swipe;

  modport source (output valid, vel_x, vel_y, is_swipe, input ready);
  modport sink (input valid, vel_x, vel_y, is_swipe, output ready);
endinterface

FILE: rtl/swipe_velocity_window.sv
// swipe velocity window: windowed pointer velocity estimator, top level
// uses svw_pkg, svw_if, svw_front, svw_queue and svw_back
//
// in_ch carries pointer samples (opcode move or release, millisecond time,
// x and y); each transfer yields exactly one transfer on out_ch with the x
// and y velocity in pixels per second and is_swipe set for a release.
// the apb port holds window_ms at byte address 0; write it only while idle.
// in_ch is taken into a front register and a two-entry command queue, so
// input keeps flowing while the back end works on an earlier sample.
// the back end handles one sample at a time: a ring walk that drops stale
// samples (skipped on an empty ring), then append, oldest-sample read,
// difference and scaling by 1000, then two serial dividers in parallel,
// one quotient bit a cycle.
// the result sits in an output register; a stalled receiver holds it and
// the back end waits with the next result, while queued input stays put.
// reset empties the ring and sets window_ms to 150; no clearing pass.
module swipe_velocity_window #(
  parameter int RING_DEPTH = svw_pkg::RING_DEPTH_DEF,
  parameter int COORD_BITS = svw_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  svw_in_if.sink                            in_ch,
  svw_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [svw_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [svw_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [svw_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  localparam int CMD_W = 1 + svw_pkg::TIME_BITS + 2 * COORD_BITS;

  logic [svw_pkg::WIN_BITS-1:0] window_r, window_nxt;
  logic                         cfg_wr;
  logic                         reg_hit;

  logic             push;
  logic [CMD_W-1:0] push_data;
  logic             q_full;
  logic             pop;
  logic [CMD_W-1:0] pop_data;
  logic             q_empty;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_hit = paddr[svw_pkg::CFG_ADDR_BITS-1:2] == svw_pkg::REG_WINDOW_MS;
  assign prdata  = reg_hit ? svw_pkg::CFG_DATA_BITS'(window_r) : '0;

  always_comb begin
    window_nxt = window_r;
    if (cfg_wr && reg_hit) begin
      window_nxt = pwdata[svw_pkg::WIN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= svw_pkg::WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  svw_front #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  svw_queue #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  svw_back #(
    .RING_DEPTH(RING_DEPTH),
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .window_ms (window_r),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/svw_div.sv
// serial restoring divider for one velocity component
// signed dividend over unsigned time, saturated to the velocity width; uses svw_pkg
module svw_div #(
  parameter int NUM_BITS = svw_pkg::COORD_BITS_DEF + 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [NUM_BITS-1:0]          num,
  input  logic [svw_pkg::TIME_BITS-1:0]       den,
  output logic                                done,
  output logic signed [svw_pkg::VEL_BITS-1:0] vel
);

  localparam int MW   = NUM_BITS - 1;
  localparam int CNTW = $clog2(MW);
  localparam int TW   = svw_pkg::TIME_BITS;
  localparam int VB   = svw_pkg::VEL_BITS;
  localparam int EW   = ((MW > VB) ? MW : VB) + 1;
  localparam logic [EW-1:0] POS_LIM = EW'((64'd1 << (VB - 1)) - 64'd1);
  localparam logic [EW-1:0] NEG_LIM = EW'(64'd1 << (VB - 1));

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt;
  logic [TW-1:0]   den_r, den_nxt;
  logic [TW-1:0]   rem_r, rem_nxt;
  logic [MW-1:0]   quo_r, quo_nxt;

  logic [TW:0]           rem_sh;
  logic [TW:0]           rem_sub;
  logic                  fits;
  logic signed [NUM_BITS-1:0] num_abs;
  logic [EW-1:0]         q_ext;
  logic [EW-1:0]         q_neg;

  assign rem_sh  = {rem_r, quo_r[MW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign num_abs = num[NUM_BITS-1] ? -num : num;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[NUM_BITS-1];
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = num_abs[MW-1:0];
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
      quo_nxt = {quo_r[MW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(MW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign q_ext = EW'(quo_r);
  assign q_neg = -q_ext;

  always_comb begin
    if (den_r == '0) begin
      vel = '0;
    end else if (neg_r) begin
      vel = (q_ext > NEG_LIM) ? NEG_LIM[VB-1:0] : q_neg[VB-1:0];
    end else begin
      vel = (q_ext > POS_LIM) ? POS_LIM[VB-1:0] : q_ext[VB-1:0];
    end
  end

  assign done = done_r;

endmodule

FILE: rtl/svw_queue.sv
// short command queue between the front and the back of the block
// register fifo; uses svw_pkg and the assertion macros
`include "swipe_velocity_window_defines.svh"

module svw_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = svw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = cnt_r == CW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  `SVW_ASSERT_NEVER(a_no_overflow, push && full)
  `SVW_ASSERT_NEVER(a_no_underflow, pop && empty)

endmodule

FILE: rtl/svw_front.sv
// front of the block: takes input transfers and packs them as commands
// feeds svw_queue; uses svw_pkg and svw_in_if
module svw_front #(
  parameter int COORD_BITS = svw_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = 1 + svw_pkg::TIME_BITS + 2 * COORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  svw_in_if.sink           in_ch,
  output logic             push,
  output logic [CMD_W-1:0] push_data,
  input  logic             q_full
);

  logic             valid_r, valid_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic             take;
  logic             is_release;

  assign push        = valid_r && !q_full;
  assign in_ch.ready = !valid_r || push;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_release  = in_ch.opcode == svw_pkg::OP_RELEASE;
  assign push_data   = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt = 1'b1;
      cmd_nxt   = {is_release, in_ch.event_time, in_ch.pos_x, in_ch.pos_y};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

FILE: rtl/svw_back.sv
// back of the block: sample ring, window trim, velocity and result register
// uses svw_pkg, svw_out_if, svw_div and the assertion macros
`include "swipe_velocity_window_defines.svh"

module svw_back #(
  parameter int RING_DEPTH = svw_pkg::RING_DEPTH_DEF,
  parameter int COORD_BITS = svw_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = 1 + svw_pkg::TIME_BITS + 2 * COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [svw_pkg::WIN_BITS-1:0] window_ms,
  input  logic                         q_empty,
  input  logic [CMD_W-1:0]             q_data,
  output logic                         pop,
  svw_out_if.source                    out_ch
);

  localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int TW    = svw_pkg::TIME_BITS;
  localparam int CB    = COORD_BITS;
  localparam int MEM_W = TW + 2 * CB;
  localparam int NW    = CB + 11;
  localparam int VB    = svw_pkg::VEL_BITS;
  localparam logic signed [NW-1:0] K_MS = NW'(svw_pkg::MS_PER_SEC);

  svw_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]    oldest_r, oldest_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;

  logic [MEM_W-1:0] ring [RING_DEPTH];
  logic [MEM_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_slot;
  logic             wr_en;

  logic                  cmd_rel;
  logic [TW-1:0]         cmd_t;
  logic signed [CB-1:0]  cmd_x, cmd_y;
  logic [TW-1:0]         rd_t;
  logic signed [CB-1:0]  rd_x, rd_y;

  logic [AW-1:0] oldest_inc;
  logic [AW:0]   slot_sum;
  logic          full;
  logic          stale;
  logic [TW-1:0] age;

  logic [TW-1:0]        dt_r, dt_nxt;
  logic signed [CB:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [NW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [NW-1:0] dx_ext, dy_ext;

  logic                 div_start;
  logic                 done_x, done_y;
  logic signed [VB-1:0] q_x, q_y;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [VB-1:0] vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic                 swipe_r, swipe_nxt;

  assign cmd_rel = cmd_r[CMD_W-1];
  assign cmd_t   = cmd_r[CMD_W-2 -: TW];
  assign cmd_x   = cmd_r[2*CB-1 -: CB];
  assign cmd_y   = cmd_r[CB-1:0];
  assign rd_t    = rd_data_r[MEM_W-1 -: TW];
  assign rd_x    = rd_data_r[2*CB-1 -: CB];
  assign rd_y    = rd_data_r[CB-1:0];

  assign oldest_inc = (oldest_r == AW'(RING_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign slot_sum   = (AW+1)'(oldest_r) + (AW+1)'(count_r);
  assign full       = count_r == CW'(RING_DEPTH);
  assign age        = cmd_t - rd_t;
  assign stale      = age > TW'(window_ms);
  assign dx_ext     = NW'(dx_r);
  assign dy_ext     = NW'(dy_r);

  always_comb begin
    if (full) begin
      wr_slot = oldest_r;
    end else if (slot_sum >= (AW+1)'(RING_DEPTH)) begin
      wr_slot = AW'(slot_sum - (AW+1)'(RING_DEPTH));
    end else begin
      wr_slot = slot_sum[AW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    dt_nxt        = dt_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    swipe_nxt     = swipe_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = oldest_r;
    div_start     = 1'b0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      svw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cmd_nxt   = q_data;
          state_nxt = (count_r == '0) ? svw_pkg::ST_WRITE : svw_pkg::ST_TRIM;
        end
      end
      svw_pkg::ST_TRIM: begin
        rd_addr = oldest_inc;
        if (stale) begin
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - 1'b1;
          if (count_r == CW'(1)) begin
            state_nxt = svw_pkg::ST_WRITE;
          end
        end else begin
          state_nxt = svw_pkg::ST_WRITE;
        end
      end
      svw_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        if (full) begin
          oldest_nxt = oldest_inc;
        end else begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = svw_pkg::ST_RD_OLD;
      end
      svw_pkg::ST_RD_OLD: begin
        state_nxt = svw_pkg::ST_DIFF;
      end
      svw_pkg::ST_DIFF: begin
        dt_nxt    = cmd_t - rd_t;
        dx_nxt    = (CB+1)'(cmd_x) - (CB+1)'(rd_x);
        dy_nxt    = (CB+1)'(cmd_y) - (CB+1)'(rd_y);
        state_nxt = svw_pkg::ST_MUL;
      end
      svw_pkg::ST_MUL: begin
        px_nxt    = dx_ext * K_MS;
        py_nxt    = dy_ext * K_MS;
        state_nxt = svw_pkg::ST_DIV_GO;
      end
      svw_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = svw_pkg::ST_DIV_WAIT;
      end
      svw_pkg::ST_DIV_WAIT: begin
        if (done_x) begin
          state_nxt = svw_pkg::ST_DONE;
        end
      end
      svw_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          vel_x_nxt     = q_x;
          vel_y_nxt     = q_y;
          swipe_nxt     = cmd_rel;
          if (cmd_rel) begin
            count_nxt  = '0;
            oldest_nxt = '0;
          end
          state_nxt = svw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svw_pkg::ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    dt_r    <= dt_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    vel_x_r <= vel_x_nxt;
    vel_y_r <= vel_y_nxt;
    swipe_r <= swipe_nxt;
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_slot] <= {cmd_t, cmd_x, cmd_y};
    end
    rd_data_r <= ring[rd_addr];
  end

  svw_div #(
    .NUM_BITS(NW)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (px_r),
    .den   (dt_r),
    .done  (done_x),
    .vel   (q_x)
  );

  svw_div #(
    .NUM_BITS(NW)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (py_r),
    .den   (dt_r),
    .done  (done_y),
    .vel   (q_y)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.vel_x    = vel_x_r;
  assign out_ch.vel_y    = vel_y_r;
  assign out_ch.is_swipe = swipe_r;

  `SVW_ASSERT_IMPL(a_trim_nonempty, state_r == svw_pkg::ST_TRIM, count_r != '0)
  `SVW_ASSERT_IMPL(a_div_lockstep, 1'b1, done_x == done_y)
  `SVW_ASSERT_NEXT(a_append_grows, state_r == svw_pkg::ST_WRITE && !full,
                   count_r == $past(count_r) + 1'b1)

endmodule
